FILE: rtl/core/itr_pkg.sv
// shared types and constants for the integer to radix text unit
package itr_pkg;

  localparam int unsigned MAX_RADIX   = 16;
  localparam int unsigned ALPHA_SYMS  = 16;
  localparam int unsigned DIGIT_CELLS = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned DIG_W       = 4;
  localparam int unsigned LEN_W       = 6;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    CFG_ALPHA_LOW  = 2'd0,
    CFG_ALPHA_HIGH = 2'd1,
    CFG_DIGIT_CNT  = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_index_e;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SYM_W-1:0]          symbol_t;
  typedef logic [CNT_W-1:0]          radix_t;

  typedef struct packed {
    logic capture;
    logic shift;
    logic load_sign;
    logic load_digit;
  } itr_cmd_t;

  typedef struct packed {
    logic is_zero;
    logic base_ok;
    logic negative;
    logic conv_done;
    logic last_digit;
  } itr_status_t;

endpackage

FILE: rtl/core/itr_if.sv
// valid/ready channel interfaces for the input value and the output symbols
interface itr_in_if;
  import itr_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itr_out_if;
  import itr_pkg::*;

  logic    valid;
  logic    ready;
  symbol_t symbol;
  logic    last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

FILE: rtl/core/integer_to_radix_text_unit.sv
// top level of the integer to radix text unit
//
//   channel  | dir | payload        | transaction
//   in_if    | in  | value (s32)    | one integer to convert
//   out_if   | out | symbol, last   | one character, last ends the text
//   cfg      | in  | index, data    | one register write per cycle with cfg_we_i
//
// an accepted value goes through the base check, then the digit cells (one
// magnitude bit per cycle), then leaves one character at a time
// zero skips the conversion and gives one character after the check
// an invalid base with a nonzero value ends after the check with no output
// output stalls hold the controller; the next value is taken once the last
// character sits in the output register; reset clears control and config
module integer_to_radix_text_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  itr_pkg::cfg_index_e cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  itr_in_if.sink              in_if,
  itr_out_if.source           out_if
);
  import itr_pkg::*;

  itr_cmd_t    cmd;
  itr_status_t status;

  itr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  itr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (in_if.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .symbol_o    (out_if.symbol),
    .last_o      (out_if.last)
  );

endmodule

FILE: rtl/core/itr_datapath.sv
// datapath: config registers, base check, radix digit cells, output register
module itr_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  itr_pkg::cfg_index_e    cfg_index_i,
  input  logic [63:0]            cfg_data_i,
  input  itr_pkg::value_t        value_i,
  input  itr_pkg::itr_cmd_t      cmd_i,
  output itr_pkg::itr_status_t   status_o,
  output itr_pkg::symbol_t       symbol_o,
  output logic                   last_o
);
  import itr_pkg::*;

  logic [CFG_W-1:0] alpha_low_q;
  logic [CFG_W-1:0] alpha_high_q;
  radix_t           radix_q;

  logic [ALPHA_SYMS-1:0][SYM_W-1:0] alpha;
  logic                             base_ok;

  logic [VALUE_W-1:0]                   mag_q, mag_d;
  logic [DIGIT_CELLS-1:0][DIG_W-1:0]    digits_q, digits_d;
  logic [LEN_W-1:0]                     len_q, len_d;
  logic [CNT_W-1:0]                     cnt_q, cnt_d;
  logic                                 zero_q, neg_q;

  logic [DIGIT_CELLS-1:0] gen, prop;
  logic [DIGIT_CELLS:0]   sum, carry;
  logic [LEN_W-1:0]       len_m1;
  logic [DIG_W-1:0]       cur_digit;
  logic [VALUE_W-1:0]     raw;
  symbol_t                symbol_q, symbol_d;
  logic                   last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= '0;
      alpha_high_q <= '0;
      radix_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA_LOW:  alpha_low_q  <= cfg_data_i;
        CFG_ALPHA_HIGH: alpha_high_q <= cfg_data_i;
        CFG_DIGIT_CNT:  radix_q      <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign alpha = {alpha_high_q, alpha_low_q};

  // independent compares over the symbols in use
  always_comb begin
    base_ok = (radix_q >= CNT_W'(2)) && (radix_q <= CNT_W'(MAX_RADIX));
    for (int i = 0; i < ALPHA_SYMS; i++) begin
      if (CNT_W'(i) < radix_q) begin
        if (alpha[i] == SYM_PLUS || alpha[i] == SYM_MINUS) base_ok = 1'b0;
        for (int j = i + 1; j < ALPHA_SYMS; j++) begin
          if (CNT_W'(j) < radix_q && alpha[i] == alpha[j]) base_ok = 1'b0;
        end
      end
    end
  end

  // each cell doubles its digit plus carry-in; carries resolved as one add
  always_comb begin
    for (int i = 0; i < DIGIT_CELLS; i++) begin
      gen[i]  = ({digits_q[i], 1'b0} >= radix_q);
      prop[i] = ({digits_q[i], 1'b1} == radix_q);
    end
    sum   = {1'b0, gen | prop} + {1'b0, gen} + {{DIGIT_CELLS{1'b0}}, mag_q[VALUE_W-1]};
    carry = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
  end

  assign len_m1    = len_q - LEN_W'(1);
  assign cur_digit = digits_q[len_m1[CNT_W-1:0]];
  assign raw       = unsigned'(value_i);

  always_comb begin
    logic [CNT_W-1:0] v;
    v        = '0;
    mag_d    = mag_q;
    digits_d = digits_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    symbol_d = symbol_q;
    last_d   = last_q;
    if (cmd_i.capture) begin
      mag_d    = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
      digits_d = '0;
      len_d    = (raw == '0) ? LEN_W'(1) : LEN_W'(0);
      cnt_d    = '0;
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < DIGIT_CELLS; i++) begin
        v = {digits_q[i], carry[i]};
        if (v >= radix_q) v = v - radix_q;
        digits_d[i] = v[DIG_W-1:0];
      end
      mag_d = {mag_q[VALUE_W-2:0], 1'b0};
      len_d = len_q + LEN_W'(carry[len_q]);
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.load_sign) begin
      symbol_d = SYM_MINUS;
      last_d   = 1'b0;
    end
    if (cmd_i.load_digit) begin
      symbol_d = alpha[cur_digit];
      last_d   = (len_q == LEN_W'(1));
      len_d    = len_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    digits_q <= digits_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      cnt_q  <= '0;
      zero_q <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      len_q <= len_d;
      cnt_q <= cnt_d;
      if (cmd_i.capture) begin
        zero_q <= (raw == '0);
        neg_q  <= raw[VALUE_W-1];
      end
    end
  end

  assign status_o.is_zero    = zero_q;
  assign status_o.base_ok    = base_ok;
  assign status_o.negative   = neg_q;
  assign status_o.conv_done  = (cnt_q == CNT_W'(DIGIT_CELLS - 1));
  assign status_o.last_digit = (len_q == LEN_W'(1));

  assign symbol_o = symbol_q;
  assign last_o   = last_q;

endmodule

FILE: rtl/core/itr_ctrl.sv
// controller: sequences check, conversion and character output
module itr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  itr_pkg::itr_status_t status_i,
  output itr_pkg::itr_cmd_t    cmd_o
);
  import itr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.is_zero) state_d = ST_DIGITS;
        else if (!status_i.base_ok)    state_d = ST_IDLE;
        else                           state_d = ST_CONV;
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (status_i.conv_done) begin
          state_d = status_i.negative ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          cmd_o.load_sign = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (slot_free) begin
          cmd_o.load_digit = 1'b1;
          out_valid_d      = 1'b1;
          if (status_i.last_digit) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: tb/tb_integer_to_radix_text_unit.sv
// self-checking testbench for the integer to radix text unit
`timescale 1ns / 1ps

module tb_integer_to_radix_text_unit;
  import itr_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned SETTLE_CYCLES   = 48;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned NUM_PHASES      = 12;
  localparam int unsigned ITEMS_PER_PHASE = 36;

  typedef struct packed {
    symbol_t symbol;
    logic    last;
  } text_char_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_VALUE
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_index_e  idx;
    logic [63:0] data;
    value_t      value;
    bit          typed;
    string       txt;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_index_e  cfg_index;
  logic [63:0] cfg_data;

  itr_in_if  in_ch ();
  itr_out_if out_ch ();

  integer_to_radix_text_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // own copy of the register file
  logic [63:0] alpha_lo_m;
  logic [63:0] alpha_hi_m;
  radix_t      radix_m;

  text_char_t  expected_chars[$];
  stim_row_t   directed_rows[$];

  int unsigned errors;
  int unsigned values_sent;
  int unsigned silent_values;
  int unsigned chars_checked;
  int unsigned reg_writes;
  int unsigned quiet_cycles;
  bit          calm;
  bit          long_hold_req;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic symbol_t alpha_sym(int unsigned k);
    return (k < 8) ? alpha_lo_m[k*8 +: 8] : alpha_hi_m[(k-8)*8 +: 8];
  endfunction

  function automatic void predict_text(value_t v);
    logic [31:0] mag;
    int unsigned n;
    symbol_t     digs[$];
    symbol_t     a;
    bit          ok;
    n = radix_m;
    if (v == 0) begin
      expected_chars.push_back('{alpha_sym(0), 1'b1});
      return;
    end
    ok = (n >= 2) && (n <= MAX_RADIX);
    for (int i = 0; ok && i < n; i++) begin
      a = alpha_sym(i);
      if (a == SYM_PLUS || a == SYM_MINUS) ok = 0;
      for (int j = i + 1; j < n; j++) begin
        if (a == alpha_sym(j)) ok = 0;
      end
    end
    if (!ok) return;
    if (v < 0) begin
      expected_chars.push_back('{SYM_MINUS, 1'b0});
      mag = -v;
    end else begin
      mag = v;
    end
    while (mag != 0) begin
      digs.push_front(alpha_sym(mag % n));
      mag = mag / n;
    end
    foreach (digs[i]) expected_chars.push_back('{digs[i], i == digs.size() - 1});
  endfunction

  function automatic void add_write(cfg_index_e idx, logic [63:0] data);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.data  = data;
    row.value = '0;
    row.typed = 1'b0;
    row.txt   = "";
    directed_rows.push_back(row);
  endfunction

  function automatic void add_value(value_t v, bit typed, string txt);
    stim_row_t row;
    row.kind  = ROW_VALUE;
    row.idx   = CFG_NONE;
    row.data  = '0;
    row.value = v;
    row.typed = typed;
    row.txt   = txt;
    directed_rows.push_back(row);
  endfunction

  // called at a falling edge, returns at a falling edge with nothing driven there
  task automatic write_reg(cfg_index_e idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ALPHA_LOW:  alpha_lo_m = data;
      CFG_ALPHA_HIGH: alpha_hi_m = data;
      CFG_DIGIT_CNT:  radix_m    = data[CNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic send_value(value_t v, bit typed, string txt);
    int unsigned before_n;
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    before_n = expected_chars.size();
    if (typed) begin
      for (int i = 0; i < txt.len(); i++) begin
        expected_chars.push_back('{txt[i], i == txt.len() - 1});
      end
    end else begin
      predict_text(v);
    end
    if (expected_chars.size() == before_n) silent_values++;
    values_sent++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // sender stops offering until every pending character has been seen
  task automatic drain_text(int unsigned settle);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_chars.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_output
    text_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b",
                                  out_ch.symbol, out_ch.last));
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.symbol !== want.symbol)
          report_mismatch($sformatf("symbol %h, expected %h", out_ch.symbol, want.symbol));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b (symbol %h)",
                                    out_ch.last, want.last, want.symbol));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d characters pending",
               quiet_cycles, expected_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [255:0] used;
    logic [7:0]   b;
    logic [4:0]   n;
    int unsigned  kind;
    int unsigned  pos;
    longint       p;
    longint       m;
    value_t       v;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_NONE;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    alpha_lo_m    = '0;
    alpha_hi_m    = '0;
    radix_m       = '0;
    errors        = 0;
    values_sent   = 0;
    silent_values = 0;
    chars_checked = 0;
    reg_writes    = 0;
    quiet_cycles  = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // registers still at reset: zero gives symbol 0, anything else is silent
    add_value(32'd0, 1'b0, "");
    add_value(32'd12345, 1'b1, "");
    add_value(32'h80000000, 1'b1, "");
    add_write(CFG_NONE, '1);
    add_write(CFG_ALPHA_LOW, "76543210");
    add_write(CFG_ALPHA_HIGH, "FEDCBA98");
    add_write(CFG_DIGIT_CNT, 64'd1);
    add_value(32'd0, 1'b1, "0");
    add_value(32'd7, 1'b1, "");
    add_write(CFG_DIGIT_CNT, 64'd10);
    add_value(32'h7FFFFFFF, 1'b1, "2147483647");
    add_value(32'h80000000, 1'b1, "-2147483648");
    add_value(-32'sd1, 1'b1, "-1");
    add_value(32'd10, 1'b1, "10");
    add_write(CFG_DIGIT_CNT, 64'd16);
    add_value(32'h7FFFFFFF, 1'b1, "7FFFFFFF");
    add_value(32'h80000000, 1'b1, "-80000000");
    add_value(32'd255, 1'b1, "FF");
    // binary gives the longest texts
    add_write(CFG_DIGIT_CNT, 64'd2);
    add_value(32'h80000000, 1'b0, "");
    add_value(32'h7FFFFFFF, 1'b0, "");
    add_value(32'd5, 1'b1, "101");
    add_write(CFG_DIGIT_CNT, 64'd17);
    add_value(32'd9, 1'b1, "");
    add_write(CFG_DIGIT_CNT, 64'd31);
    add_value(-32'sd9, 1'b1, "");
    add_value(32'd0, 1'b1, "0");
    // repeated symbol, then signs inside and outside the used part
    add_write(CFG_ALPHA_LOW, "76543200");
    add_write(CFG_DIGIT_CNT, 64'd3);
    add_value(32'd4, 1'b1, "");
    add_write(CFG_ALPHA_LOW, "765432+0");
    add_value(32'd4, 1'b1, "");
    add_write(CFG_ALPHA_LOW, "765-3210");
    add_value(32'd4, 1'b0, "");
    add_write(CFG_DIGIT_CNT, 64'd5);
    add_value(32'd4, 1'b1, "");
    // a zero byte is an ordinary symbol
    add_write(CFG_ALPHA_LOW, 64'h0706050403020100);
    add_write(CFG_ALPHA_HIGH, '1);
    add_write(CFG_DIGIT_CNT, 64'd9);
    add_value(-32'sd100, 1'b0, "");
    add_value(32'd0, 1'b0, "");
    add_write(CFG_DIGIT_CNT, 64'd16);
    add_value(32'd1, 1'b1, "");

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        drain_text(SETTLE_CYCLES);
        write_reg(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        send_value(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].txt);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_text(SETTLE_CYCLES);
      if (ph >= NUM_PHASES - 2) calm = 1'b1;

      // distinct symbols, never a sign
      used = '0;
      used[SYM_PLUS]  = 1'b1;
      used[SYM_MINUS] = 1'b1;
      for (int k = 0; k < ALPHA_SYMS; k++) begin
        do b = 8'($urandom_range(0, 255)); while (used[b]);
        used[b] = 1'b1;
        if (k < 8) lo[k*8 +: 8] = b;
        else hi[(k-8)*8 +: 8] = b;
      end
      kind = (ph == 3) ? 9 : $urandom_range(0, 9);
      case (kind)
        0: n = 5'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31));
        1, 2: begin
          n   = 5'($urandom_range(2, MAX_RADIX));
          pos = $urandom_range(1, n - 1);
          if (kind == 1) b = lo[7:0];
          else b = $urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS;
          if (pos < 8) lo[pos*8 +: 8] = b;
          else hi[(pos-8)*8 +: 8] = b;
        end
        3: n = 5'd2;
        4: n = 5'(MAX_RADIX);
        default: n = 5'($urandom_range(2, MAX_RADIX));
      endcase
      write_reg(CFG_ALPHA_LOW, lo);
      write_reg(CFG_ALPHA_HIGH, hi);
      write_reg(CFG_DIGIT_CNT, {$urandom, 27'($urandom_range(0, 7)), n});

      for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
        // block fills up behind a stalled output
        if (ph == 3 && it == 10) long_hold_req = 1'b1;
        if (ph == 5 && it == 18) drain_text(0);
        case ($urandom_range(0, 9))
          0: v = '0;
          1: begin
            case ($urandom_range(0, 3))
              0: v = 32'h80000000;
              1: v = 32'h7FFFFFFF;
              2: v = '1;
              default: v = 32'd1;
            endcase
          end
          2: begin
            v = $urandom_range(1, 300);
            if ($urandom_range(0, 1)) v = -v;
          end
          3: begin
            // around a power of the radix, where the digit count changes
            m = (radix_m >= 2 && radix_m <= MAX_RADIX) ? radix_m : 10;
            p = 1;
            repeat ($urandom_range(1, 31)) if (p * m <= 64'h7FFFFFFF) p = p * m;
            p = p + longint'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1)) p = -p;
            v = p[31:0];
          end
          default: v = $urandom;
        endcase
        send_value(v, 1'b0, "");
      end
    end

    drain_text(SETTLE_CYCLES);
    $display("covered %0d values and %0d register writes across radix, alphabet and sign cases",
             values_sent, reg_writes);
    $display("compared %0d characters; %0d values produced no text", chars_checked,
             silent_values);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
